### src/bipartite_check_assert.svh
// Assertion macros for the bipartite check block.
`ifndef BIPARTITE_CHECK_ASSERT_SVH
`define BIPARTITE_CHECK_ASSERT_SVH
`ifndef SYNTH
`define BC_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bipartite_check: assertion failed");
`define BC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bipartite_check: assertion failed");
`else
`define BC_ASSERT(label, cond)
`define BC_ASSERT_IMP(label, ante, cons)
`endif
`endif

### src/bc_pkg.sv
// Shared command and status types for the bipartite check block.
package bc_pkg;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic init;
		logic start_walk;
		logic skip;
		logic row_cap;
		logic step;
		logic push;
		logic pop;
		logic pop_cap;
		logic fail;
		logic emit;
	} bc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pick_end;
		logic pick_colored;
		logic j_end;
		logic edge_bit;
		logic nb_colored;
		logic nb_same;
		logic stack_empty;
		logic stack_full;
	} bc_sts_t;

endpackage

### src/bc_ram.sv
// Generic simple dual-port RAM with registered read.
module bc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/bc_ctrl.sv
// Controller state machine for the bipartite check walk.
module bc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            last_row,
	output logic            out_valid,
	input  logic            out_ready,
	input  bc_pkg::bc_sts_t sts,
	output bc_pkg::bc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PICK    = 3'd1;
	localparam logic [2:0] ST_ROWWAIT = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_POPWAIT = 3'd4;
	localparam logic [2:0] ST_FINISH  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_row) begin
						cmd.init = 1'b1;
						state_d  = ST_PICK;
					end
				end
			end
			ST_PICK: begin
				if (sts.pick_end) begin
					state_d = ST_FINISH;
				end else if (sts.pick_colored) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.start_walk = 1'b1;
					state_d        = ST_ROWWAIT;
				end
			end
			ST_ROWWAIT: begin
				cmd.row_cap = 1'b1;
				state_d     = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.j_end) begin
					if (sts.stack_empty) begin
						state_d = ST_PICK;
					end else begin
						cmd.pop = 1'b1;
						state_d = ST_POPWAIT;
					end
				end else if (sts.edge_bit && !sts.nb_colored) begin
					cmd.push = 1'b1;
					state_d  = ST_ROWWAIT;
				end else if (sts.edge_bit && sts.nb_same) begin
					cmd.fail = 1'b1;
					state_d  = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_POPWAIT: begin
				cmd.pop_cap = 1'b1;
				state_d     = ST_ROWWAIT;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### src/bc_dp.sv
// Datapath: adjacency store, colors, walk stack and scan registers.
module bc_dp #(
	parameter int MAX_NODES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bc_pkg::bc_cmd_t cmd,
	output bc_pkg::bc_sts_t sts,
	input  logic            cfg_we,
	input  logic [6:0]      cfg_wdata,
	input  logic [5:0]      row_index,
	input  logic [63:0]     neighbour_mask,
	output logic            is_bipartite
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = AW + CW;

	logic [6:0]           node_count_q;
	logic [CW-1:0]        n_w;
	logic [CW-1:0]        s_q;
	logic [CW-1:0]        j_q;
	logic [AW-1:0]        v_q;
	logic [AW-1:0]        depth_q;
	logic                 cv_q;
	logic                 ok_q;
	logic                 is_bipartite_q;
	logic                 vbit_q;
	logic [MAX_NODES-1:0] row_q;
	logic [MAX_NODES-1:0] colored_q;
	logic [MAX_NODES-1:0] side_q;
	logic [MAX_NODES-1:0] row_valid_q;

	logic                 row_we;
	logic [AW-1:0]        row_waddr;
	logic                 row_re;
	logic [AW-1:0]        row_raddr;
	logic [MAX_NODES-1:0] row_rdata;
	logic [AW-1:0]        s_idx;
	logic [AW-1:0]        j_idx;
	logic [SW-1:0]        stk_wdata;
	logic [SW-1:0]        stk_rdata;
	logic [AW-1:0]        stk_raddr;
	logic [AW-1:0]        pop_node;

	// node count clamped to 1..MAX_NODES
	always_comb begin
		if (node_count_q == 7'd0) begin
			n_w = CW'(1);
		end else if (node_count_q > 7'(MAX_NODES)) begin
			n_w = CW'(MAX_NODES);
		end else begin
			n_w = node_count_q[CW-1:0];
		end
	end

	assign s_idx     = s_q[AW-1:0];
	assign j_idx     = j_q[AW-1:0];
	assign pop_node  = stk_rdata[SW-1:CW];
	assign row_we    = cmd.load && ({1'b0, row_index} < 7'(MAX_NODES));
	assign row_waddr = row_index[AW-1:0];
	assign row_re    = cmd.start_walk || cmd.push || cmd.pop_cap;
	assign stk_wdata = {v_q, j_q + CW'(1)};
	assign stk_raddr = depth_q - AW'(1);

	always_comb begin
		if (cmd.push) begin
			row_raddr = j_idx;
		end else if (cmd.pop_cap) begin
			row_raddr = pop_node;
		end else begin
			row_raddr = s_idx;
		end
	end

	bc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (neighbour_mask[MAX_NODES-1:0]),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	bc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (depth_q),
		.wdata (stk_wdata),
		.re    (cmd.pop),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 7'd64;
			colored_q    <= '0;
			row_valid_q  <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (row_we) begin
				row_valid_q[row_waddr] <= 1'b1;
			end
			if (cmd.start_walk) begin
				colored_q[s_idx] <= 1'b1;
			end
			if (cmd.push) begin
				colored_q[j_idx] <= 1'b1;
			end
			if (cmd.emit) begin
				colored_q   <= '0;
				row_valid_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			s_q  <= '0;
			ok_q <= 1'b1;
		end
		if (cmd.skip) begin
			s_q <= s_q + CW'(1);
		end
		if (cmd.start_walk) begin
			side_q[s_idx] <= 1'b0;
			cv_q          <= 1'b0;
			v_q           <= s_idx;
			j_q           <= '0;
			depth_q       <= '0;
			s_q           <= s_q + CW'(1);
		end
		if (row_re) begin
			vbit_q <= row_valid_q[row_raddr];
		end
		if (cmd.row_cap) begin
			row_q <= vbit_q ? row_rdata : '0;
		end
		if (cmd.step) begin
			j_q <= j_q + CW'(1);
		end
		if (cmd.push) begin
			side_q[j_idx] <= ~cv_q;
			cv_q          <= ~cv_q;
			v_q           <= j_idx;
			j_q           <= '0;
			depth_q       <= depth_q + AW'(1);
		end
		if (cmd.pop) begin
			depth_q <= stk_raddr;
		end
		if (cmd.pop_cap) begin
			v_q  <= pop_node;
			j_q  <= stk_rdata[CW-1:0];
			cv_q <= side_q[pop_node];
		end
		if (cmd.fail) begin
			ok_q <= 1'b0;
		end
		if (cmd.emit) begin
			is_bipartite_q <= ok_q;
		end
	end

	always_comb begin
		sts              = '0;
		sts.pick_end     = (s_q >= n_w);
		sts.pick_colored = colored_q[s_idx];
		sts.j_end        = (j_q >= n_w);
		sts.edge_bit     = row_q[j_idx];
		sts.nb_colored   = colored_q[j_idx];
		sts.nb_same      = (side_q[j_idx] == cv_q);
		sts.stack_empty  = (depth_q == '0);
		sts.stack_full   = (depth_q == AW'(MAX_NODES - 1));
	end

	assign is_bipartite = is_bipartite_q;

endmodule

### src/bipartite_check.sv
// Row requests are taken one per cycle in idle; a row without the last mark gives no result.
// The last row starts the walk: the start-node pointer steps over every node, and each walked node
// costs a row fetch plus a scan of its row; each back-track adds a stack read and a row fetch.
// The next row is taken from the cycle after the verdict is loaded, even while it waits.
// Reset clears the color flags, row valid flags and control state and sets the node count to 64, at once.
`include "bipartite_check_assert.svh"

module bipartite_check #(
	parameter int MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  row_index,
	input  logic [63:0] neighbour_mask,
	input  logic        last_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_bipartite,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	bc_pkg::bc_cmd_t cmd;
	bc_pkg::bc_sts_t sts;

	bc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_row  (last_row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bc_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.row_index      (row_index),
		.neighbour_mask (neighbour_mask),
		.is_bipartite   (is_bipartite)
	);

	`BC_ASSERT_IMP(a_push_room, cmd.push, !sts.stack_full)
	`BC_ASSERT_IMP(a_pop_nonempty, cmd.pop, !sts.stack_empty)
	`BC_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid || out_ready)
	`BC_ASSERT(a_idle_quiet, !(in_ready && (cmd.push || cmd.pop || cmd.emit)))

endmodule
